// File: rtl/urxrb_pkg.sv
// shared types and constants for the uart receive ring buffer
package urxrb_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned FILL_W  = 6;
	localparam logic [BYTE_W-1:0] MASK_RESET = 8'h1c;

	typedef enum logic {
		KIND_RX   = 1'b0,
		KIND_READ = 1'b1
	} item_kind_t;

	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

endpackage

// File: rtl/uart_rx_ring_buffer_core.sv
// top level of the uart receive byte buffer built as a shifting chain of cells
//
//  channel | signals                                    | side
//  --------+--------------------------------------------+---------
//  input   | in_valid, in_stall, kind, line_status,     | consumer
//          | rx_byte                                    |
//  output  | out_valid, out_stall, read_valid,          | producer
//          | read_byte, fill_count, overflow_flag,      |
//          | line_error_bits                            |
//  config  | cfg_we, cfg_wdata                          | write only
//
// a pop shifts every cell toward the head and a push loads the first free
// cell. the result sits in an output register, so a new item is taken
// while no result waits or while the waiting one is taken. reset empties
// the chain and clears the sticky flags; error_mask resets to 0x1c.
// BUFFER_DEPTH-1 cells hold bytes.
module uart_rx_ring_buffer_core
	import urxrb_pkg::*;
#(
	parameter int unsigned BUFFER_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [BYTE_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              kind,
	input  logic [BYTE_W-1:0] line_status,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              read_valid,
	output logic [BYTE_W-1:0] read_byte,
	output logic [FILL_W-1:0] fill_count,
	output logic              overflow_flag,
	output logic [BYTE_W-1:0] line_error_bits
);

	localparam int unsigned NCELL = BUFFER_DEPTH - 1;
	localparam int unsigned CW    = $clog2(BUFFER_DEPTH);

	logic [BYTE_W-1:0] mask_q;
	logic [CW-1:0]     count_q;
	logic              ovf_q;
	logic [BYTE_W-1:0] lerr_q;
	logic              out_valid_q;
	logic              read_valid_q;
	logic [BYTE_W-1:0] read_byte_q;
	logic [FILL_W-1:0] fill_q;

	logic              accept;
	logic              is_read;
	logic              err;
	logic              full;
	logic              push;
	logic              pop;
	logic [CW-1:0]     count_nxt;
	logic [CW+FILL_W-1:0] count_ext;
	logic              ovf_nxt;
	logic [BYTE_W-1:0] lerr_nxt;
	cell_ctrl_t        ctrl;

	logic              occ_chain  [0:NCELL];
	logic [BYTE_W-1:0] data_chain [0:NCELL];
	logic              prev_chain [0:NCELL-1];

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign is_read  = (item_kind_t'(kind) == KIND_READ);
	assign err      = (line_status & mask_q) != '0;
	assign full     = count_q == CW'(BUFFER_DEPTH - 1);
	assign push     = accept && !is_read && !err && !full;
	assign pop      = accept && is_read && (count_q != '0);

	assign ctrl.push = push;
	assign ctrl.pop  = pop;

	always_comb begin
		count_nxt = count_q;
		if (push) begin
			count_nxt = count_q + CW'(1);
		end else if (pop) begin
			count_nxt = count_q - CW'(1);
		end
		ovf_nxt  = ovf_q || (accept && !is_read && !err && full);
		lerr_nxt = (accept && !is_read && err) ? (lerr_q | line_status) : lerr_q;
	end

	assign count_ext = {{FILL_W{1'b0}}, count_nxt};

	// chain ends: nothing beyond the last cell, always occupied before the head
	assign occ_chain[NCELL]  = 1'b0;
	assign data_chain[NCELL] = '0;

	always_comb begin
		prev_chain[0] = 1'b1;
		for (int i = 1; i < NCELL; i++) begin
			prev_chain[i] = occ_chain[i-1];
		end
	end

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		urxrb_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.push_data(rx_byte),
			.prev_occ (prev_chain[g]),
			.next_occ (occ_chain[g+1]),
			.next_data(data_chain[g+1]),
			.occ      (occ_chain[g]),
			.data     (data_chain[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= MASK_RESET;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			lerr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mask_q <= cfg_wdata;
			end
			if (accept) begin
				count_q     <= count_nxt;
				ovf_q       <= ovf_nxt;
				lerr_q      <= lerr_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			read_valid_q <= pop;
			read_byte_q  <= pop ? data_chain[0] : '0;
			fill_q       <= count_ext[FILL_W-1:0];
		end
	end

	assign out_valid       = out_valid_q;
	assign read_valid      = read_valid_q;
	assign read_byte       = read_byte_q;
	assign fill_count      = fill_q;
	assign overflow_flag   = ovf_q;
	assign line_error_bits = lerr_q;

endmodule

// File: rtl/urxrb_cell.sv
// one storage cell of the byte chain, head side toward cell zero
module urxrb_cell
	import urxrb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic [BYTE_W-1:0] push_data,
	input  logic              prev_occ,
	input  logic              next_occ,
	input  logic [BYTE_W-1:0] next_data,
	output logic              occ,
	output logic [BYTE_W-1:0] data
);

	logic              occ_q;
	logic [BYTE_W-1:0] data_q;
	logic              take;

	// tail cell: first empty cell after an occupied one
	assign take = ctrl.push && !occ_q && prev_occ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.pop) begin
			occ_q <= next_occ;
		end else if (take) begin
			occ_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			data_q <= next_data;
		end else if (take) begin
			data_q <= push_data;
		end
	end

	assign occ  = occ_q;
	assign data = data_q;

endmodule

// File: dv/tb_uart_rx_ring_buffer_core.sv
// testbench for the uart receive ring buffer: random byte and read traffic checked by a scoreboard
module tb_uart_rx_ring_buffer_core
	import urxrb_pkg::*;
();

	localparam int unsigned DEPTH       = 64;
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct {
		logic              read_valid;
		logic [BYTE_W-1:0] read_byte;
		logic [FILL_W-1:0] fill_count;
		logic              overflow_flag;
		logic [BYTE_W-1:0] line_error_bits;
	} fifo_result_t;

	class fifo_scoreboard;
		logic [BYTE_W-1:0] held_bytes[$];
		logic              overflow_sticky;
		logic [BYTE_W-1:0] error_sticky;
		logic [BYTE_W-1:0] error_mask;
		fifo_result_t      pending_results[$];
		int unsigned       errors;

		function new();
			overflow_sticky = 1'b0;
			error_sticky = '0;
			error_mask = MASK_RESET;
			errors = 0;
		endfunction

		function void set_mask(logic [BYTE_W-1:0] m);
			error_mask = m;
		endfunction

		function int unsigned pending();
			return pending_results.size();
		endfunction

		function void note_input(item_kind_t k, logic [BYTE_W-1:0] status,
			logic [BYTE_W-1:0] data);
			fifo_result_t r;
			r.read_valid = 1'b0;
			r.read_byte = '0;
			if (k == KIND_RX) begin
				if ((status & error_mask) != '0)
					error_sticky = error_sticky | status;
				else if (held_bytes.size() >= DEPTH - 1)
					overflow_sticky = 1'b1;
				else
					held_bytes.push_back(data);
			end else if (held_bytes.size() != 0) begin
				r.read_valid = 1'b1;
				r.read_byte = held_bytes.pop_front();
			end
			r.fill_count = FILL_W'(held_bytes.size());
			r.overflow_flag = overflow_sticky;
			r.line_error_bits = error_sticky;
			pending_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [BYTE_W-1:0] want,
			logic [BYTE_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(fifo_result_t got);
			fifo_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: result transfer with none expected, read_byte actual %0h",
					$time, got.read_byte);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("read_valid", BYTE_W'(want.read_valid), BYTE_W'(got.read_valid));
			compare_field("read_byte", want.read_byte, got.read_byte);
			compare_field("fill_count", BYTE_W'(want.fill_count), BYTE_W'(got.fill_count));
			compare_field("overflow_flag", BYTE_W'(want.overflow_flag),
				BYTE_W'(got.overflow_flag));
			compare_field("line_error_bits", want.line_error_bits, got.line_error_bits);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [BYTE_W-1:0] cfg_wdata;
	logic              in_valid;
	logic              in_stall;
	logic              kind;
	logic [BYTE_W-1:0] line_status;
	logic [BYTE_W-1:0] rx_byte;
	logic              out_valid;
	logic              out_stall;
	logic              read_valid;
	logic [BYTE_W-1:0] read_byte;
	logic [FILL_W-1:0] fill_count;
	logic              overflow_flag;
	logic [BYTE_W-1:0] line_error_bits;

	int unsigned    cycles = 0;
	fifo_scoreboard sb = new();

	uart_rx_ring_buffer_core #(
		.BUFFER_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.line_status(line_status),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_valid(read_valid),
		.read_byte(read_byte),
		.fill_count(fill_count),
		.overflow_flag(overflow_flag),
		.line_error_bits(line_error_bits)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// transfer monitor
	always @(posedge clk) begin
		fifo_result_t got;
		if (arst_n === 1'b1) begin
			if (in_valid && !in_stall)
				sb.note_input(item_kind_t'(kind), line_status, rx_byte);
			if (out_valid === 1'b1 && !out_stall) begin
				got.read_valid = read_valid;
				got.read_byte = read_byte;
				got.fill_count = fill_count;
				got.overflow_flag = overflow_flag;
				got.line_error_bits = line_error_bits;
				sb.check_result(got);
			end
		end
	end

	// result side back-pressure
	initial begin
		int unsigned run;
		int unsigned hold;
		forever begin
			case ($urandom_range(0, 9))
				0: run = $urandom_range(100, 300);
				1, 2: run = $urandom_range(7, 30);
				default: run = $urandom_range(1, 6);
			endcase
			hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
			out_stall <= 1'b0;
			repeat (run) @(posedge clk);
			out_stall <= 1'b1;
			repeat (hold) @(posedge clk);
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(5, 40);
	endfunction

	function automatic logic [BYTE_W-1:0] make_status(bit with_error);
		logic [BYTE_W-1:0] s;
		if (with_error && sb.error_mask != '0) begin
			do s = BYTE_W'($urandom); while ((s & sb.error_mask) == '0);
		end else begin
			s = BYTE_W'($urandom) & ~sb.error_mask;
		end
		return s;
	endfunction

	task automatic send_item(item_kind_t k, logic [BYTE_W-1:0] s, logic [BYTE_W-1:0] d,
		int unsigned gap);
		kind <= k;
		line_status <= s;
		rx_byte <= d;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain(int unsigned extra);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_error_mask(logic [BYTE_W-1:0] m);
		cfg_wdata <= m;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_mask(m);
	endtask

	task automatic run_phase(int unsigned n_items);
		int unsigned left;
		int unsigned chunk;
		int unsigned push_pct;
		int unsigned err_pct;
		bit          burst;
		left = n_items;
		while (left > 0) begin
			chunk = $urandom_range(20, 60);
			if (chunk > left)
				chunk = left;
			case ($urandom_range(0, 3))
				0: push_pct = 90;
				1: push_pct = 15;
				default: push_pct = 55;
			endcase
			case ($urandom_range(0, 2))
				0: err_pct = 0;
				1: err_pct = 8;
				default: err_pct = 35;
			endcase
			burst = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < chunk; i++) begin
				if ($urandom_range(0, 99) < push_pct)
					send_item(KIND_RX, make_status($urandom_range(0, 99) < err_pct),
						BYTE_W'($urandom), burst ? 0 : pick_gap());
				else
					send_item(KIND_READ, BYTE_W'($urandom), BYTE_W'($urandom),
						burst ? 0 : pick_gap());
			end
			left -= chunk;
			// sometimes the sender holds off until the buffer has answered everything
			if ($urandom_range(0, 5) == 0)
				drain(0);
		end
	endtask

	initial begin
		logic [BYTE_W-1:0] masks[6];
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		kind <= KIND_RX;
		line_status <= '0;
		rx_byte <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items under the reset mask
		send_item(KIND_READ, 8'h00, 8'h00, pick_gap());
		send_item(KIND_RX, 8'h00, 8'h00, pick_gap());
		send_item(KIND_RX, 8'he3, 8'hff, pick_gap());
		send_item(KIND_RX, 8'h04, 8'h55, pick_gap());
		send_item(KIND_RX, 8'h08, 8'haa, pick_gap());
		send_item(KIND_RX, 8'h10, 8'h33, pick_gap());
		send_item(KIND_READ, 8'hff, 8'hff, pick_gap());
		send_item(KIND_READ, 8'h00, 8'h00, pick_gap());
		send_item(KIND_READ, 8'h00, 8'h00, pick_gap());
		send_item(KIND_RX, 8'hff, 8'h12, pick_gap());
		send_item(KIND_RX, 8'h01, 8'h80, pick_gap());
		send_item(KIND_RX, 8'h20, 8'h01, pick_gap());
		send_item(KIND_READ, 8'h00, 8'h00, pick_gap());
		send_item(KIND_READ, 8'h00, 8'h00, pick_gap());
		send_item(KIND_READ, 8'h00, 8'h00, pick_gap());

		masks[0] = 8'h00;
		masks[1] = 8'hff;
		masks[2] = BYTE_W'($urandom);
		masks[3] = MASK_RESET;
		masks[4] = BYTE_W'($urandom);
		masks[5] = 8'h80;
		foreach (masks[p]) begin
			drain(3);
			write_error_mask(masks[p]);
			run_phase(215);
		end

		drain(5);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: filelist.f
rtl/urxrb_pkg.sv
rtl/urxrb_cell.sv
rtl/uart_rx_ring_buffer_core.sv
dv/tb_uart_rx_ring_buffer_core.sv
